### rtl/lcs_pkg.sv
`timescale 1ns / 1ps

package lcs_pkg;

    // Pixel width and full-scale value
    localparam int PIXEL_BITS = 8;
    localparam int NUM_BITS   = 2 * PIXEL_BITS;
    localparam int CNT_BITS   = $clog2(PIXEL_BITS + 1);

    localparam logic [PIXEL_BITS-1:0] PIXEL_MAX  = {PIXEL_BITS{1'b1}};
    localparam logic [PIXEL_BITS-1:0] PIXEL_ZERO = {PIXEL_BITS{1'b0}};

    // Operation codes carried on the operation field
    localparam logic OP_MEASURE = 1'b0;
    localparam logic OP_STRETCH = 1'b1;

    typedef logic [PIXEL_BITS-1:0] pixel_t;
    typedef logic [NUM_BITS-1:0]   num_t;
    typedef logic [CNT_BITS-1:0]   cnt_t;

endpackage

### rtl/lcs_div.sv
`timescale 1ns / 1ps

// Restoring divider, one quotient bit a cycle through one shared subtractor.
// The caller guarantees the quotient fits in PIXEL_BITS bits, i.e. the upper
// half of the dividend is below the divisor.
module lcs_div
    import lcs_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   start,
    input  num_t   dividend,
    input  pixel_t divisor,
    output logic   done,
    output pixel_t quotient
);

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    cnt_t                  cnt_reg, cnt_next;
    pixel_t                rem_reg, rem_next;
    pixel_t                shf_reg, shf_next;
    logic [PIXEL_BITS:0]   trial;
    logic [PIXEL_BITS:0]   diff;
    logic                  fits;

    assign trial = {rem_reg, shf_reg[PIXEL_BITS-1]};
    assign diff  = trial - {1'b0, divisor};
    assign fits  = (trial >= {1'b0, divisor});

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        shf_next  = shf_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_BITS'(PIXEL_BITS);
            rem_next  = dividend[NUM_BITS-1:PIXEL_BITS];
            shf_next  = dividend[PIXEL_BITS-1:0];
        end
        else if (busy_reg)
        begin
            // subtract when it fits, shift the quotient bit in from the right
            rem_next = fits ? diff[PIXEL_BITS-1:0] : trial[PIXEL_BITS-1:0];
            shf_next = {shf_reg[PIXEL_BITS-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_BITS'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        shf_reg <= shf_next;
    end

    assign done     = done_reg;
    assign quotient = shf_reg;

endmodule

### rtl/linear_contrast_stretch.sv
`timescale 1ns / 1ps

// Min/max linear contrast stretch for 8-bit pixels, two passes per frame.
// Input channel: in_valid/in_stall carry one word of operation, first, pixel.
// A measure word (operation 0) updates the running minimum and maximum; a word
// flagged first restarts both to its pixel. A stretch word (operation 1) yields
// floor((pixel - low) * 255 / (high - low)), clamped to 0 below the minimum and
// to 255 above the maximum, and 0 for a flat frame (high not above low).
// Output channel: out_valid/out_stall carry one word per input word:
// stretched (0 for a measure word), low and high after that word.
// Measure words and clamped or flat stretch words go from acceptance straight to
// S_DONE; a stretch word that divides passes through S_DIV first. One word at a
// time: in_stall stays high from acceptance until the result has moved into the
// output register. The divide is set by the restoring divider, one quotient bit
// per cycle.
// Reset clears the running minimum and maximum to 0 and empties the output register.
// While the receiver stalls, the output word holds; the next input word may be
// accepted and worked on, and its result waits until the output register frees.
module linear_contrast_stretch
    import lcs_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   in_valid,
    output logic   in_stall,
    input  logic   operation,
    input  logic   first,
    input  pixel_t pixel,
    output logic   out_valid,
    input  logic   out_stall,
    output pixel_t stretched,
    output pixel_t low,
    output pixel_t high
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DIV  = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    logic [1:0] state_reg, state_next;
    pixel_t     lowest_reg, lowest_next;
    pixel_t     highest_reg, highest_next;
    pixel_t     res_reg, res_next;
    logic       out_valid_reg, out_valid_next;
    pixel_t     out_res_reg, out_low_reg, out_high_reg;

    logic       accept;
    logic       slot_free;
    logic       div_start;
    logic       div_done;
    pixel_t     div_quo;
    pixel_t     offset;
    num_t       numer;
    logic       flat, below, above;

    assign accept    = in_valid && (state_reg == S_IDLE);
    assign slot_free = !out_valid_reg || !out_stall;

    // (pixel - low) * 255 as a shift and a subtract
    assign offset = pixel - lowest_reg;
    assign numer  = {offset, PIXEL_ZERO} - {PIXEL_ZERO, offset};

    assign flat  = (highest_reg <= lowest_reg);
    assign below = (pixel <= lowest_reg);
    assign above = (pixel >= highest_reg);

    always_comb
    begin
        state_next     = state_reg;
        lowest_next    = lowest_reg;
        highest_next   = highest_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg;
        div_start      = 1'b0;

        // drop the output word once taken
        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (operation == OP_MEASURE)
                    begin
                        res_next   = PIXEL_ZERO;
                        state_next = S_DONE;
                        if (first)
                        begin
                            lowest_next  = pixel;
                            highest_next = pixel;
                        end
                        else
                        begin
                            if (pixel > highest_reg)
                                highest_next = pixel;
                            if (pixel < lowest_reg)
                                lowest_next = pixel;
                        end
                    end
                    else if (flat || below)
                    begin
                        res_next   = PIXEL_ZERO;
                        state_next = S_DONE;
                    end
                    else if (above)
                    begin
                        res_next   = PIXEL_MAX;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        // quotient stays below full scale, so it fits the divider
                        div_start  = 1'b1;
                        state_next = S_DIV;
                    end
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    res_next   = div_quo;
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                // hold the result until the output register frees
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    lcs_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (numer),
        .divisor  (highest_reg - lowest_reg),
        .done     (div_done),
        .quotient (div_quo)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            lowest_reg    <= PIXEL_ZERO;
            highest_reg   <= PIXEL_ZERO;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            lowest_reg    <= lowest_next;
            highest_reg   <= highest_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload: load the output word when the result moves across
    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
        if (state_reg == S_DONE && slot_free)
        begin
            out_res_reg  <= res_reg;
            out_low_reg  <= lowest_reg;
            out_high_reg <= highest_reg;
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign stretched = out_res_reg;
    assign low       = out_low_reg;
    assign high      = out_high_reg;

endmodule

### rtl/lcs_chk.sv
`timescale 1ns / 1ps

module lcs_chk
    import lcs_pkg::*;
(
    input logic   clk,
    input logic   rst_n,
    input logic   in_valid,
    input logic   in_stall,
    input logic   out_valid,
    input logic   out_stall,
    input pixel_t stretched,
    input pixel_t low,
    input pixel_t high
);

    // a stalled output word stays
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(stretched)
            && $stable(low) && $stable(high))
        else $error("output word changed under stall");

    // one word at a time: the block is busy right after taking a word
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input taken again without a busy cycle");

    // the running minimum never passes the maximum
    a_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> low <= high)
        else $error("minimum above maximum");

    // a flat frame stretches to zero
    a_flat_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (stretched != PIXEL_ZERO) |-> high > low)
        else $error("non-zero result from a flat frame");

endmodule

bind linear_contrast_stretch lcs_chk u_lcs_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stretched (stretched),
    .low       (low),
    .high      (high)
);

### tb/linear_contrast_stretch_tb.sv
`timescale 1ns / 1ps

module linear_contrast_stretch_tb;

    import lcs_pkg::*;

    // Give up well beyond the slowest legal run: every word waiting out the
    // longest sender gap, the divider and the longest receiver stall, plus
    // the long receiver hold-offs.
    localparam int CYCLE_LIMIT  = 400000;
    localparam int TARGET_WORDS = 1600;
    localparam int HOLD_CYCLES  = 250;
    localparam int SETTLE       = 30;

    // One input word as queued for the driver, with its lead-in gap and a
    // request to let the block drain completely before it is offered.
    typedef struct {
        logic   operation;
        logic   first;
        pixel_t pixel;
        int     gap;
        bit     drain;
    } pixel_word_t;

    // What the block should return for one accepted word.
    typedef struct {
        pixel_t stretched;
        pixel_t low;
        pixel_t high;
    } stretch_result_t;

    logic   clk       = 1'b0;
    logic   rst_n     = 1'b0;
    logic   in_valid  = 1'b0;
    logic   in_stall;
    logic   operation = OP_MEASURE;
    logic   first     = 1'b0;
    pixel_t pixel     = PIXEL_ZERO;
    logic   out_valid;
    logic   out_stall = 1'b0;
    pixel_t stretched;
    pixel_t low;
    pixel_t high;

    pixel_word_t     pending_words[$];
    stretch_result_t results_due[$];

    // Predictor copy of the running frame extremes
    pixel_t run_min = PIXEL_ZERO;
    pixel_t run_max = PIXEL_ZERO;

    int  errors      = 0;
    int  words_in    = 0;
    int  words_out   = 0;
    int  cycle_count = 0;
    bit  in_taken    = 1'b0;
    bit  out_taken   = 1'b0;

    // Driver state
    pixel_word_t cur_word;
    bit          on_bus    = 1'b0;
    bit          loaded    = 1'b0;
    int          gap_left  = 0;

    // Receiver state
    int hold_left = 0;
    int hold_from = -1;
    int wait_left = 0;

    // Stimulus build state
    bit sender_calm = 1'b0;
    bit drain_next  = 1'b0;

    linear_contrast_stretch u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .operation (operation),
        .first     (first),
        .pixel     (pixel),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stretched (stretched),
        .low       (low),
        .high      (high)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Advance the running extremes for one word and work out its result.
    // A measure word updates (or, when flagged first, restarts) the extremes;
    // a stretch word leaves them alone and maps the pixel onto full scale.
    function automatic stretch_result_t predict_word(logic op, logic first_flag, pixel_t pix);
        stretch_result_t r;
        num_t            span;
        num_t            scaled;
        r.stretched = PIXEL_ZERO;
        if (op == OP_MEASURE)
        begin
            if (first_flag)
            begin
                run_min = pix;
                run_max = pix;
            end
            else
            begin
                if (pix > run_max)
                    run_max = pix;
                if (pix < run_min)
                    run_min = pix;
            end
        end
        // A flat frame gives 0 before any clamping is considered; so does a
        // pixel at or below the minimum.
        else if (run_max > run_min && pix > run_min)
        begin
            if (pix >= run_max)
                r.stretched = PIXEL_MAX;
            else
            begin
                span   = num_t'(run_max - run_min);
                scaled = num_t'(pix - run_min) * num_t'(PIXEL_MAX);
                r.stretched = pixel_t'(scaled / span);
            end
        end
        r.low  = run_min;
        r.high = run_max;
        return r;
    endfunction

    task automatic flag_mismatch(string what, int got, int want);
        $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
        errors++;
    endtask

    // Append one word to the driver queue; the gap is drawn here so that
    // calm bursts can force back-to-back offers.
    task automatic queue_word(logic op, logic first_flag, pixel_t pix);
        pixel_word_t w;
        w.operation = op;
        w.first     = first_flag;
        w.pixel     = pix;
        w.gap       = sender_calm ? 0 : $urandom_range(0, 9);
        w.drain     = drain_next;
        drain_next  = 1'b0;
        pending_words.push_back(w);
    endtask

    // Sample both handshakes at the rising edge, before the block's own
    // registers move. Predict on input acceptance, check on output acceptance.
    always @(posedge clk)
    begin
        stretch_result_t want;
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAILED: results differ");
            $finish;
        end
        else if (rst_n)
        begin
            in_taken  <= in_valid && !in_stall;
            out_taken <= out_valid && !out_stall;
            if (in_valid && !in_stall)
            begin
                results_due.push_back(predict_word(operation, first, pixel));
                words_in <= words_in + 1;
            end
            if (out_valid && !out_stall)
            begin
                words_out <= words_out + 1;
                if (results_due.size() == 0)
                    flag_mismatch("unexpected word (stretched)", stretched, -1);
                else
                begin
                    want = results_due.pop_front();
                    if (stretched !== want.stretched)
                        flag_mismatch("stretched", stretched, want.stretched);
                    if (low !== want.low)
                        flag_mismatch("low", low, want.low);
                    if (high !== want.high)
                        flag_mismatch("high", high, want.high);
                end
            end
        end
    end

    // Sender: drop the word once it has been taken, load the next one, hold
    // off for a drain when asked, count down its gap, then offer it and hold
    // it steady until accepted.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (on_bus && in_taken)
                on_bus = 1'b0;
            if (!on_bus)
            begin
                if (!loaded && pending_words.size() != 0)
                begin
                    cur_word = pending_words.pop_front();
                    gap_left = cur_word.gap;
                    loaded   = 1'b1;
                end
                if (loaded && !(cur_word.drain && results_due.size() != 0))
                begin
                    if (gap_left > 0)
                        gap_left--;
                    else
                    begin
                        on_bus = 1'b1;
                        loaded = 1'b0;
                    end
                end
            end
            in_valid  <= on_bus;
            operation <= cur_word.operation;
            first     <= cur_word.first;
            pixel     <= cur_word.pixel;
        end
    end

    // Long receiver hold-off: twice in the run, stall the output for a long
    // stretch so the block fills and pushes back on its input.
    always @(negedge clk)
    begin
        if (hold_left != 0)
            hold_left <= hold_left - 1;
        else if ((words_in == 300 || words_in == 1100) && hold_from != words_in)
        begin
            hold_left <= HOLD_CYCLES;
            hold_from <= words_in;
        end
    end

    // Receiver: after each taken word draw a short stall; some stretches of
    // the run take every word at once.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (out_taken)
                wait_left = (((words_out / 150) % 3) == 0) ? 0 : $urandom_range(0, 9);
            else if (wait_left > 0)
                wait_left--;
            out_stall <= (hold_left != 0) || (wait_left != 0);
        end
    end

    initial
    begin
        int     n_meas;
        int     n_str;
        int     n_noise;
        int     lo_b;
        int     hi_b;
        int     swap;
        bit     drained_once;
        pixel_t pick;

        drained_once = 1'b0;

        // Directed opening. Measure before any first word: start from the
        // reset extremes of 0.
        queue_word(OP_MEASURE, 1'b0, 8'h80);
        queue_word(OP_STRETCH, 1'b0, 8'h40);
        queue_word(OP_STRETCH, 1'b0, 8'h00);
        queue_word(OP_STRETCH, 1'b0, 8'hFF);
        // Flat frame at full scale
        queue_word(OP_MEASURE, 1'b1, 8'hFF);
        queue_word(OP_STRETCH, 1'b0, 8'hFF);
        queue_word(OP_STRETCH, 1'b0, 8'h00);
        // Full-range frame; a first flag on a stretch word must be ignored
        queue_word(OP_MEASURE, 1'b1, 8'h00);
        queue_word(OP_MEASURE, 1'b0, 8'hFF);
        queue_word(OP_MEASURE, 1'b0, 8'h55);
        queue_word(OP_STRETCH, 1'b0, 8'h01);
        queue_word(OP_STRETCH, 1'b0, 8'hFE);
        queue_word(OP_STRETCH, 1'b1, 8'hAA);
        // Narrow frame: below the minimum, above the maximum, just inside
        queue_word(OP_MEASURE, 1'b1, 8'h40);
        queue_word(OP_MEASURE, 1'b0, 8'hC0);
        queue_word(OP_STRETCH, 1'b0, 8'h10);
        queue_word(OP_STRETCH, 1'b0, 8'hF0);
        queue_word(OP_STRETCH, 1'b0, 8'h41);
        queue_word(OP_STRETCH, 1'b0, 8'hBF);
        // Span of one
        queue_word(OP_MEASURE, 1'b1, 8'h7F);
        queue_word(OP_MEASURE, 1'b0, 8'h80);
        queue_word(OP_STRETCH, 1'b0, 8'h7F);
        queue_word(OP_STRETCH, 1'b0, 8'h80);
        // Flat frame takes precedence over the clamps
        queue_word(OP_MEASURE, 1'b1, 8'h33);
        queue_word(OP_STRETCH, 1'b0, 8'h00);

        // Pause the sender until the block has fully drained
        drain_next = 1'b1;

        // Random frames: mostly a measure pass opened by a first word and
        // followed by a stretch pass, with occasional noise words between.
        while (pending_words.size() < TARGET_WORDS)
        begin
            if (!drained_once && pending_words.size() > 900)
            begin
                drain_next   = 1'b1;
                drained_once = 1'b1;
            end
            sender_calm = ($urandom_range(0, 5) == 0);
            if ($urandom_range(0, 6) == 0)
            begin
                n_noise = $urandom_range(1, 4);
                for (int i = 0; i < n_noise; i++)
                    queue_word(1'($urandom), 1'($urandom), pixel_t'($urandom));
            end
            else
            begin
                lo_b = $urandom_range(0, 255);
                hi_b = $urandom_range(0, 255);
                if ($urandom_range(0, 7) == 0)
                begin
                    lo_b = 0;
                    hi_b = 255;
                end
                if (lo_b > hi_b)
                begin
                    swap = lo_b;
                    lo_b = hi_b;
                    hi_b = swap;
                end
                n_meas = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                     : $urandom_range(1, 6);
                for (int i = 0; i < n_meas; i++)
                    queue_word(OP_MEASURE, i == 0, pixel_t'($urandom_range(lo_b, hi_b)));
                n_str = $urandom_range(1, 16);
                for (int i = 0; i < n_str; i++)
                begin
                    if ($urandom_range(0, 3) == 0)
                        pick = pixel_t'($urandom);
                    else
                        pick = pixel_t'($urandom_range(lo_b, hi_b));
                    queue_word(OP_STRETCH, $urandom_range(0, 7) == 0, pick);
                end
            end
        end
        sender_calm = 1'b0;

        // Hold reset, then release it away from the sampling edge
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Wait for every word to be taken, every result to arrive, then a
        // little longer to catch anything spurious.
        while (pending_words.size() != 0 || on_bus || loaded)
            @(posedge clk);
        while (results_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);

        if (errors == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
